[rtl/hs_pkg.sv]
`timescale 1ns / 1ps

package hs_pkg;

    typedef logic signed [31:0] t_word;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BUILD_RD,
        S_BUILD_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EXT_RD,
        S_EXT_SWAP,
        S_OUT_RD,
        S_OUT_WAIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BUILD_RD,
        OP_BUILD_LD,
        OP_SIFT_RD,
        OP_SIFT_CMP,
        OP_EXT_RD,
        OP_EXT_SWAP,
        OP_OUT_RD,
        OP_OUT_LD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic k_zero;
        logic sift_done;
        logic out_free;
        logic out_last;
    } t_status;

endpackage

[rtl/hs_ctrl.sv]
`timescale 1ns / 1ps

module hs_ctrl
    import hs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_extract, n_extract;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_extract <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_extract <= n_extract;
        end
    end

    // Next state.
    always_comb begin
        n_state   = r_state;
        n_extract = r_extract;
        case (r_state)
            S_LOAD: begin
                if (accept && i_in_last) begin
                    n_state   = S_BUILD_RD;
                    n_extract = 1'b0;
                end
            end
            S_BUILD_RD: begin
                if (i_status.k_zero) begin
                    n_state   = S_EXT_RD;
                    n_extract = 1'b1;
                end else begin
                    n_state = S_BUILD_LD;
                end
            end
            S_BUILD_LD: n_state = S_SIFT_RD;
            S_SIFT_RD:  n_state = S_SIFT_CMP;
            S_SIFT_CMP: begin
                if (!i_status.sift_done) begin
                    n_state = S_SIFT_RD;
                end else if (r_extract) begin
                    n_state = S_EXT_RD;
                end else begin
                    n_state = S_BUILD_RD;
                end
            end
            S_EXT_RD: begin
                n_state = i_status.k_zero ? S_OUT_RD : S_EXT_SWAP;
            end
            S_EXT_SWAP: n_state = S_SIFT_RD;
            S_OUT_RD:   n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.out_last ? S_LOAD : S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.op   = accept ? OP_LOAD : OP_NONE;
            end
            S_BUILD_RD: o_cmd.op = OP_BUILD_RD;
            S_BUILD_LD: o_cmd.op = OP_BUILD_LD;
            S_SIFT_RD:  o_cmd.op = OP_SIFT_RD;
            S_SIFT_CMP: o_cmd.op = OP_SIFT_CMP;
            S_EXT_RD:   o_cmd.op = i_status.k_zero ? OP_NONE : OP_EXT_RD;
            S_EXT_SWAP: o_cmd.op = OP_EXT_SWAP;
            S_OUT_RD:   o_cmd.op = OP_OUT_RD;
            S_OUT_WAIT: o_cmd.op = i_status.out_free ? OP_OUT_LD : OP_NONE;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

[rtl/hs_dp.sv]
`timescale 1ns / 1ps

module hs_dp
    import hs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_status o_status,
    input  t_word   i_value,
    input  logic    i_last,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_word   o_out_value,
    output logic    o_out_last,
    output logic    o_out_drop
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = AW + 2;

    t_word mem [DEPTH];

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_k, n_k;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_size, n_size;
    t_word         r_cur, n_cur;
    t_word         r_rd_a, r_rd_b;
    logic          r_out_valid, n_out_valid;
    t_word         r_out_value, n_out_value;
    logic          r_out_last, n_out_last;
    logic          r_out_drop, n_out_drop;

    logic          wr_en, rd_en_a, rd_en_b;
    logic [AW-1:0] wr_addr, addr_a, addr_b;
    t_word         wr_data;

    logic          full;
    logic [CW-1:0] cnt_inc, k_m1;
    logic [XW-1:0] left, right, size_x, best_idx;
    logic          sel_l, sel_r, out_last;
    t_word         best_val;

    assign full    = (r_cnt == CW'(DEPTH));
    assign cnt_inc = full ? r_cnt : r_cnt + 1'b1;
    assign k_m1    = r_k - 1'b1;
    assign left    = {1'b0, r_pos, 1'b1};
    assign right   = left + 1'b1;
    assign size_x  = XW'(r_size);
    assign out_last = ((CW + 1)'(r_k) + 1'b1) == (CW + 1)'(r_cnt);

    // Larger of the sifted value and the children that are still in the heap.
    always_comb begin
        sel_l    = (left < size_x) && (r_rd_a > r_cur);
        best_val = sel_l ? r_rd_a : r_cur;
        best_idx = sel_l ? left : XW'(r_pos);
        sel_r    = (right < size_x) && (r_rd_b > best_val);
        if (sel_r) begin
            best_val = r_rd_b;
            best_idx = right;
        end
    end

    assign o_status.k_zero    = (r_k == '0);
    assign o_status.sift_done = !(sel_l || sel_r);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.out_last  = out_last;

    always_comb begin
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_pos       = r_pos;
        n_size      = r_size;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_drop  = r_out_drop;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = r_cur;
        rd_en_a     = 1'b0;
        rd_en_b     = 1'b0;
        addr_a      = '0;
        addr_b      = '0;
        case (i_cmd.op)
            OP_LOAD: begin
                if (!full) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cnt[AW-1:0];
                    wr_data = i_value;
                    n_cnt   = cnt_inc;
                end else begin
                    n_ovf = 1'b1;
                end
                if (i_last) begin
                    n_size = cnt_inc;
                    n_k    = cnt_inc >> 1;
                end
            end
            OP_BUILD_RD: begin
                if (r_k == '0) begin
                    n_k = r_cnt;
                end else begin
                    rd_en_a = 1'b1;
                    addr_a  = k_m1[AW-1:0];
                    n_pos   = k_m1[AW-1:0];
                    n_k     = k_m1;
                end
            end
            OP_BUILD_LD: begin
                n_cur = r_rd_a;
            end
            OP_SIFT_RD: begin
                rd_en_a = 1'b1;
                rd_en_b = 1'b1;
                addr_a  = left[AW-1:0];
                addr_b  = right[AW-1:0];
            end
            OP_SIFT_CMP: begin
                // The sifted value rides in r_cur; only its final slot is written.
                wr_en   = 1'b1;
                wr_addr = r_pos;
                if (sel_l || sel_r) begin
                    wr_data = best_val;
                    n_pos   = best_idx[AW-1:0];
                end else begin
                    wr_data = r_cur;
                end
            end
            OP_EXT_RD: begin
                rd_en_a = 1'b1;
                rd_en_b = 1'b1;
                addr_a  = '0;
                addr_b  = k_m1[AW-1:0];
                n_k     = k_m1;
            end
            OP_EXT_SWAP: begin
                // The maximum goes to the vacated slot; the last element sifts from the root.
                wr_en   = 1'b1;
                wr_addr = r_k[AW-1:0];
                wr_data = r_rd_a;
                n_cur   = r_rd_b;
                n_pos   = '0;
                n_size  = r_k;
            end
            OP_OUT_RD: begin
                rd_en_a = 1'b1;
                addr_a  = r_k[AW-1:0];
            end
            OP_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out_value = r_rd_a;
                n_out_last  = out_last;
                n_out_drop  = r_ovf;
                if (out_last) begin
                    n_k   = '0;
                    n_cnt = '0;
                    n_ovf = 1'b0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            r_rd_a <= mem[addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_size      <= n_size;
        r_cur       <= n_cur;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
        r_out_drop  <= n_out_drop;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;
    assign o_out_drop  = r_out_drop;

endmodule

[rtl/heap_sorter.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                        Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata = value, tlast = is_last
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata = value_res,
//                                                       tlast = is_last_res, tuser = dropped
//
// Loading accepts one request per cycle. After the last element of a batch of n, the sort
// runs in a single heap memory with two read ports and one write port: every level of a
// sift reads both children (S_SIFT_RD), then compares and writes (S_SIFT_CMP), and each
// result is read from the memory and then loaded into the output register. Input is held
// off from the last request until the final result has entered the output register.
// A stalled output holds the sort at its current result.
// Reset is synchronous and empties the batch.

module heap_sorter
    import hs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] value_res
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // [0] dropped
);

    t_cmd    cmd;
    t_status status;
    t_word   out_value;

    hs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_last  (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_value     (t_word'(i_s_axis_tdata)),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_value (out_value),
        .o_out_last  (o_m_axis_tlast),
        .o_out_drop  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = 32'(out_value);

endmodule

[bench/tb_heap_sorter.sv]
`timescale 1ns / 1ps

module tb_heap_sorter;
    import hs_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic  pause;    // hold back until every result so far has come out
        t_word value;
        logic  last;
    } t_request;

    typedef struct packed {
        t_word value;
        logic  last;
        logic  dropped;
    } t_sorted_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;      // [31:0] value
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;           // [31:0] value_res
    logic        o_m_axis_tlast;
    logic        o_m_axis_tuser;           // [0] dropped

    t_request     pending_reqs[$];
    t_sorted_word sorted_due[$];
    t_word        batch_words[$];
    logic         batch_overflow = 1'b0;
    bit           req_taken = 1'b0;
    int           reqs_sent = 0;
    int           results_seen = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           errors = 0;

    heap_sorter #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Collects one element unless the batch is full; on the final one the batch is sorted in
    // ascending order and every collected element becomes an expected result.
    task automatic sort_batch_in(input t_word value, input logic last);
        t_word        ordered[$];
        t_word        tmp;
        t_sorted_word res;
        int           i;
        int           j;
        if (batch_words.size() < DEPTH) begin
            batch_words.push_back(value);
        end else begin
            batch_overflow = 1'b1;
        end
        if (last) begin
            ordered = batch_words;
            for (i = 1; i < ordered.size(); i++) begin
                tmp = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > tmp) begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = tmp;
            end
            for (i = 0; i < ordered.size(); i++) begin
                res.value = ordered[i];
                res.last = (i == ordered.size() - 1);
                res.dropped = batch_overflow;
                sorted_due.push_back(res);
            end
            batch_words.delete();
            batch_overflow = 1'b0;
        end
    endtask

    // Accepted requests and results are both taken at the rising edge.
    always @(posedge i_clk) begin
        t_sorted_word want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sort_batch_in(t_word'(i_s_axis_tdata), i_s_axis_tlast);
                void'(pending_reqs.pop_front());
                req_taken = 1'b1;
                reqs_sent++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (sorted_due.size() == 0) begin
                    $error("unexpected result: value_res %0d", t_word'(o_m_axis_tdata));
                    errors++;
                end else begin
                    want = sorted_due.pop_front();
                    if (t_word'(o_m_axis_tdata) !== want.value) begin
                        $error("value_res: expected %0d, got %0d", want.value,
                               t_word'(o_m_axis_tdata));
                        errors++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("is_last_res: expected %0b, got %0b", want.last,
                               o_m_axis_tlast);
                        errors++;
                    end
                    if (o_m_axis_tuser !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped,
                               o_m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    // Sender: holds a request until it is taken, then idles now and again,
    // except over a calm stretch of requests.
    always @(negedge i_clk) begin
        bit hold;
        bit idle;
        hold = i_s_axis_tvalid && !req_taken;
        req_taken = 1'b0;
        idle = ($urandom_range(99) < 15) && !(reqs_sent >= 120 && reqs_sent < 200);
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!hold) begin
            if (pending_reqs.size() != 0 && pending_reqs[0].pause) begin
                if (sorted_due.size() == 0) begin
                    void'(pending_reqs.pop_front());
                end
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0 || idle) begin
                i_s_axis_tvalid <= 1'b0;
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= pending_reqs[0].value;
                i_s_axis_tlast <= pending_reqs[0].last;
            end
        end
    end

    // Receiver: random stalls, one long hold-off that starts while a request is
    // waiting at the stalled input, so that the next batch backs up there, and a
    // calm stretch with no stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (results_seen >= 30 && !hold_done && i_s_axis_tvalid
                     && !o_s_axis_tready) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_m_axis_tready <= 1'b0;
        end else if (results_seen >= 150 && results_seen < 260) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= 15);
        end
    end

    function automatic t_word rand_word();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return t_word'($urandom_range(4)) - 2;  // small range, plenty of ties
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic add_request(input t_word value, input logic last);
        t_request r;
        r.pause = 1'b0;
        r.value = value;
        r.last = last;
        pending_reqs.push_back(r);
    endtask

    task automatic add_pause();
        t_request r;
        r = '0;
        r.pause = 1'b1;
        pending_reqs.push_back(r);
    endtask

    task automatic add_batch(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            add_request(rand_word(), i == n - 1);
        end
    endtask

    initial begin
        int total;
        int n;
        int k;

        // Extremes and repeated values in one batch.
        add_request(32'sh7FFF_FFFF, 1'b0);
        add_request(32'sh8000_0000, 1'b0);
        add_request(32'sh0000_0000, 1'b0);
        add_request(-32'sd1, 1'b0);
        add_request(32'sd1, 1'b0);
        add_request(32'sh8000_0000, 1'b0);
        add_request(32'sh7FFF_FFFF, 1'b1);
        // A batch of one element, then a pair of equal values.
        add_request(-32'sd5, 1'b1);
        add_pause();
        add_request(32'sd42, 1'b0);
        add_request(32'sd42, 1'b1);
        // Descending and already ascending input.
        add_request(32'sd100, 1'b0);
        add_request(32'sd50, 1'b0);
        add_request(-32'sd50, 1'b0);
        add_request(-32'sd100, 1'b1);
        add_request(-32'sd3, 1'b0);
        add_request(-32'sd2, 1'b0);
        add_request(32'sd7, 1'b0);
        add_request(32'sd9, 1'b1);
        add_pause();

        // Random batches: mostly short, a full store, and one that overflows so
        // that the final element itself is discarded.
        total = 0;
        k = 0;
        while (total < 250) begin
            if (k == 3) begin
                n = DEPTH + 2;
            end else if (k == 8) begin
                n = DEPTH;
            end else if ($urandom_range(9) == 0) begin
                n = $urandom_range(40, 20);
            end else begin
                n = $urandom_range(12, 1);
            end
            add_batch(n);
            if ($urandom_range(4) == 0) begin
                add_pause();
            end
            total += n;
            k++;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_reqs.size() != 0 || sorted_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[heap_sorter.f]
rtl/hs_pkg.sv
rtl/hs_ctrl.sv
rtl/hs_dp.sv
rtl/heap_sorter.sv
bench/tb_heap_sorter.sv
